### design/d8_flow_direction_unit_defines.svh
// Assertion macros shared by the flow direction design files.
`ifndef D8_FLOW_DIRECTION_UNIT_DEFINES_SVH
`define D8_FLOW_DIRECTION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define D8FD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define D8FD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define D8FD_ASSERT(lbl, prop, msg)
`define D8FD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### design/d8fd_pkg.sv
package d8fd_pkg;

  localparam int MaxWidth   = 1024;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int WidthRegW  = ColW + 1;
  localparam int RowW       = 16;
  localparam int ElevW      = 16;
  localparam int AxialShift = 16;
  localparam int SlopeW     = ElevW + AxialShift;
  localparam int DirW       = 4;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 32;
  localparam int OutPadW    = OutDataW - (ColW + RowW + DirW);

  localparam logic [ElevW-1:0]     WeightDiag    = 16'd46341;
  localparam logic [DirW-1:0]      DirNone       = 4'd8;
  localparam logic [CfgIdxW-1:0]   RegGridWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0]   RegGridHeight = 2'd1;
  localparam logic [WidthRegW-1:0] WidthReset    = 11'd256;
  localparam logic [RowW-1:0]      HeightReset   = 16'd256;

  localparam int NbDx [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int NbDy [8] = '{0, -1, -1, -1, 0, 1, 1, 1};

  typedef struct packed {
    logic no_left;
    logic no_right;
    logic no_up;
    logic no_down;
  } nb_mask_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            last;
    nb_mask_t        mask;
  } emit_t;

  typedef struct packed {
    logic [ColW-1:0]  col;
    logic [ElevW-1:0] value;
    logic             primed;
    emit_t            emit;
  } item_t;

  typedef struct packed {
    logic [ElevW-1:0] older;
    logic [ElevW-1:0] recent;
  } line_pair_t;

  typedef struct packed {
    logic [7:0][SlopeW-1:0] slope;
    logic [ColW-1:0]        col;
    logic [RowW-1:0]        row;
    logic                   last;
  } s2_t;

endpackage

### design/d8fd_ctrl.sv
`include "d8_flow_direction_unit_defines.svh"

module d8fd_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [d8fd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [d8fd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           accept_i,
  input  logic                           cmd_i,
  input  logic [d8fd_pkg::ElevW-1:0]     elev_i,
  output logic                           keep_o,
  output d8fd_pkg::item_t                item_o
);

  logic [d8fd_pkg::WidthRegW-1:0] width_q, width_d, w_eff;
  logic [d8fd_pkg::RowW-1:0]      height_q, height_d, h_eff;
  logic [d8fd_pkg::ColW-1:0]      in_col_q, in_col_d, cur_in_col;
  logic [1:0]                     in_row_q, in_row_d, cur_in_row;
  logic [d8fd_pkg::ColW-1:0]      em_col_q, em_col_d, cur_em_col;
  logic [d8fd_pkg::RowW-1:0]      em_row_q, em_row_d, cur_em_row;
  logic                           frame_done_q, frame_done_d;
  logic                           restart, primed, in_col_last, cfg_hit;

  always_comb begin
    if (width_q == '0) begin
      w_eff = d8fd_pkg::WidthRegW'(1);
    end else if (width_q > d8fd_pkg::WidthRegW'(d8fd_pkg::MaxWidth)) begin
      w_eff = d8fd_pkg::WidthRegW'(d8fd_pkg::MaxWidth);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q == '0) ? d8fd_pkg::RowW'(1) : height_q;
  end

  // A sample that arrives after the final cell was reported opens a new frame.
  assign restart    = frame_done_q && !cmd_i;
  assign keep_o     = !(frame_done_q && cmd_i);
  assign cur_in_col = restart ? '0 : in_col_q;
  assign cur_in_row = restart ? '0 : in_row_q;
  assign cur_em_col = restart ? '0 : em_col_q;
  assign cur_em_row = restart ? '0 : em_row_q;

  assign primed      = (cur_in_row == 2'd2) || ((cur_in_row == 2'd1) && (cur_in_col != '0));
  assign in_col_last = ({1'b0, cur_in_col} + d8fd_pkg::WidthRegW'(1)) >= w_eff;

  always_comb begin
    item_o.col              = cur_in_col;
    item_o.value            = cmd_i ? '0 : elev_i;
    item_o.primed           = primed;
    item_o.emit.col         = cur_em_col;
    item_o.emit.row         = cur_em_row;
    item_o.emit.mask.no_left  = (cur_em_col == '0);
    item_o.emit.mask.no_right = ({1'b0, cur_em_col} + d8fd_pkg::WidthRegW'(1)) >= w_eff;
    item_o.emit.mask.no_up    = (cur_em_row == '0);
    item_o.emit.mask.no_down  = ({1'b0, cur_em_row} + 17'd1) >= {1'b0, h_eff};
    item_o.emit.last        = item_o.emit.mask.no_right && item_o.emit.mask.no_down;
  end

  assign cfg_hit = cfg_we_i &&
                   ((cfg_idx_i == d8fd_pkg::RegGridWidth) ||
                    (cfg_idx_i == d8fd_pkg::RegGridHeight));

  always_comb begin
    width_d      = width_q;
    height_d     = height_q;
    in_col_d     = in_col_q;
    in_row_d     = in_row_q;
    em_col_d     = em_col_q;
    em_row_d     = em_row_q;
    frame_done_d = frame_done_q;
    if (cfg_hit) begin
      if (cfg_idx_i == d8fd_pkg::RegGridWidth) begin
        width_d = cfg_wdata_i[d8fd_pkg::WidthRegW-1:0];
      end else begin
        height_d = cfg_wdata_i[d8fd_pkg::RowW-1:0];
      end
      in_col_d     = '0;
      in_row_d     = '0;
      em_col_d     = '0;
      em_row_d     = '0;
      frame_done_d = 1'b0;
    end else if (accept_i && keep_o) begin
      in_col_d     = in_col_last ? '0 : cur_in_col + d8fd_pkg::ColW'(1);
      in_row_d     = (in_col_last && (cur_in_row != 2'd2)) ? cur_in_row + 2'd1 : cur_in_row;
      em_col_d     = cur_em_col;
      em_row_d     = cur_em_row;
      frame_done_d = 1'b0;
      if (primed) begin
        if (item_o.emit.last) begin
          frame_done_d = 1'b1;
        end else if (item_o.emit.mask.no_right) begin
          em_col_d = '0;
          em_row_d = cur_em_row + d8fd_pkg::RowW'(1);
        end else begin
          em_col_d = cur_em_col + d8fd_pkg::ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= d8fd_pkg::WidthReset;
      height_q     <= d8fd_pkg::HeightReset;
      in_col_q     <= '0;
      in_row_q     <= '0;
      em_col_q     <= '0;
      em_row_q     <= '0;
      frame_done_q <= 1'b0;
    end else begin
      width_q      <= width_d;
      height_q     <= height_d;
      in_col_q     <= in_col_d;
      in_row_q     <= in_row_d;
      em_col_q     <= em_col_d;
      em_row_q     <= em_row_d;
      frame_done_q <= frame_done_d;
    end
  end

  `D8FD_ASSERT(a_done_from_last, $rose(frame_done_q) |-> $past(accept_i && keep_o && item_o.primed && item_o.emit.last), "frame end without a final cell")

endmodule

### design/d8fd_line_store.sv
module d8fd_line_store (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [d8fd_pkg::ColW-1:0]    rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [d8fd_pkg::ColW-1:0]    wr_addr_i,
  input  d8fd_pkg::line_pair_t         wr_data_i,
  output d8fd_pkg::line_pair_t         rd_data_o
);

  d8fd_pkg::line_pair_t mem_q [d8fd_pkg::MaxWidth];
  d8fd_pkg::line_pair_t rd_q;

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

### design/d8fd_window.sv
`include "d8_flow_direction_unit_defines.svh"

module d8fd_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  d8fd_pkg::line_pair_t        lines_i,
  input  logic [d8fd_pkg::ElevW-1:0]  value_i,
  input  logic                        primed_i,
  input  d8fd_pkg::emit_t             emit_i,
  output logic                        ready_o,
  output logic                        s2_vld_o,
  output d8fd_pkg::s2_t               s2_o,
  input  logic                        s2_ready_i
);

  logic [d8fd_pkg::ElevW-1:0] win_q [3][3];
  logic                       sw_vld_q;
  d8fd_pkg::emit_t            sw_emit_q;
  logic                       s2_vld_q;
  d8fd_pkg::s2_t              s2_q, s2_d;
  logic                       s2_free, sw_adv;
  logic [d8fd_pkg::ElevW-1:0] center;
  logic [d8fd_pkg::ElevW-1:0] nb [8];
  logic [d8fd_pkg::ElevW-1:0] drop [8];
  logic                       nb_ok [8];

  assign s2_free = !s2_vld_q || s2_ready_i;
  assign sw_adv  = sw_vld_q && s2_free;
  assign ready_o = !sw_vld_q || s2_free;

  // Columns are x-1, x, x+1; rows are y-1, y, y+1 around the reported cell.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int c = 0; c < 2; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= win_q[c+1][r];
        end
      end
      win_q[2][0] <= lines_i.older;
      win_q[2][1] <= lines_i.recent;
      win_q[2][2] <= value_i;
      sw_emit_q   <= emit_i;
    end
    if (sw_adv) begin
      s2_q <= s2_d;
    end
  end

  assign center = win_q[1][1];

  always_comb begin
    s2_d.col  = sw_emit_q.col;
    s2_d.row  = sw_emit_q.row;
    s2_d.last = sw_emit_q.last;
    for (int k = 0; k < 8; k++) begin
      nb[k]    = win_q[1 + d8fd_pkg::NbDx[k]][1 + d8fd_pkg::NbDy[k]];
      nb_ok[k] = !(((d8fd_pkg::NbDx[k] < 0) && sw_emit_q.mask.no_left)  ||
                   ((d8fd_pkg::NbDx[k] > 0) && sw_emit_q.mask.no_right) ||
                   ((d8fd_pkg::NbDy[k] < 0) && sw_emit_q.mask.no_up)    ||
                   ((d8fd_pkg::NbDy[k] > 0) && sw_emit_q.mask.no_down));
      drop[k]  = center - nb[k];
      s2_d.slope[k] = '0;
      if (nb_ok[k] && (center > nb[k])) begin
        if ((d8fd_pkg::NbDx[k] != 0) && (d8fd_pkg::NbDy[k] != 0)) begin
          s2_d.slope[k] = d8fd_pkg::SlopeW'(drop[k]) * d8fd_pkg::SlopeW'(d8fd_pkg::WeightDiag);
        end else begin
          s2_d.slope[k] = d8fd_pkg::SlopeW'(drop[k]) << d8fd_pkg::AxialShift;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (shift_i) begin
        sw_vld_q <= primed_i;
      end else if (sw_adv) begin
        sw_vld_q <= 1'b0;
      end
      if (sw_adv) begin
        s2_vld_q <= 1'b1;
      end else if (s2_ready_i) begin
        s2_vld_q <= 1'b0;
      end
    end
  end

  assign s2_vld_o = s2_vld_q;
  assign s2_o     = s2_q;

  `D8FD_ASSERT(a_no_shift_over_pending, shift_i |-> (!sw_vld_q || s2_free), "window shifted over a pending cell")

endmodule

### design/d8fd_pick.sv
`include "d8_flow_direction_unit_defines.svh"

module d8fd_pick (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s2_vld_i,
  input  d8fd_pkg::s2_t                  s2_i,
  output logic                           s2_ready_o,
  output logic                           out_vld_o,
  input  logic                           out_ready_i,
  output logic [d8fd_pkg::OutDataW-1:0]  out_data_o,
  output logic                           out_last_o
);

  logic [d8fd_pkg::SlopeW-1:0] l1_val [4];
  logic [2:0]                  l1_idx [4];
  logic [d8fd_pkg::SlopeW-1:0] l2_val [2];
  logic [2:0]                  l2_idx [2];
  logic [d8fd_pkg::SlopeW-1:0] best_val;
  logic [2:0]                  best_idx;
  logic [d8fd_pkg::DirW-1:0]   dir_d, dir_q;
  logic [d8fd_pkg::ColW-1:0]   col_q;
  logic [d8fd_pkg::RowW-1:0]   row_q;
  logic                        last_q;
  logic                        out_vld_q;
  logic                        load;

  // On equal slopes the lower direction code is kept.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (s2_i.slope[2*i+1] > s2_i.slope[2*i]) begin
        l1_val[i] = s2_i.slope[2*i+1];
        l1_idx[i] = 3'(2*i+1);
      end else begin
        l1_val[i] = s2_i.slope[2*i];
        l1_idx[i] = 3'(2*i);
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (l1_val[2*i+1] > l1_val[2*i]) begin
        l2_val[i] = l1_val[2*i+1];
        l2_idx[i] = l1_idx[2*i+1];
      end else begin
        l2_val[i] = l1_val[2*i];
        l2_idx[i] = l1_idx[2*i];
      end
    end
    if (l2_val[1] > l2_val[0]) begin
      best_val = l2_val[1];
      best_idx = l2_idx[1];
    end else begin
      best_val = l2_val[0];
      best_idx = l2_idx[0];
    end
    dir_d = (best_val == '0) ? d8fd_pkg::DirNone : {1'b0, best_idx};
  end

  assign s2_ready_o = !out_vld_q || out_ready_i;
  assign load       = s2_vld_i && s2_ready_o;

  always_ff @(posedge clk_i) begin
    if (load) begin
      dir_q  <= dir_d;
      col_q  <= s2_i.col;
      row_q  <= s2_i.row;
      last_q <= s2_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_data_o = {{d8fd_pkg::OutPadW{1'b0}}, dir_q, row_q, col_q};
  assign out_last_o = last_q;

  `D8FD_ASSERT_ALWAYS(a_idle_after_reset, !rst_ni |=> !out_vld_q, "result valid right after reset")

endmodule

### design/d8_flow_direction_unit.sv
// D8 flow direction over an elevation raster streamed in row-major order, column
// fastest. Each request is either an elevation sample (tuser low) or a flush tick
// (tuser high); one request is taken every clock cycle when the output is not
// stalled. For each cell the unit reports the steepest strictly downhill neighbor
// among the eight inside the raster (codes 0 to 7, or 8 when there is none), with
// diagonal drops weighted by 46341/65536 and the first code winning ties. The
// result for a cell comes out after grid_width + 1 further requests, so a frame
// is drained with grid_width + 1 flush ticks; tlast marks the final cell, after
// which flush ticks are dropped and the next sample opens a new frame. A flush
// tick inside the raster counts as elevation zero. Writing grid_width or
// grid_height restarts the frame; a width of 0 acts as 1, above 1024 as 1024,
// and a height of 0 as 1. The two previous rows sit in one line store with a
// single read and a single write port, read when a request is taken and written
// back as the request moves on into the window; there is no clearing pass after
// reset. From request to result register the steps are line store read,
// 3x3 window, slope products and the compare tree filling the result register.
module d8_flow_direction_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [d8fd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [d8fd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] elevation
  input  logic [d8fd_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] command
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [9:0] cell_column, [25:10] cell_row, [29:26] direction, [31:30] zero
  output logic [d8fd_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast
);

  logic                 accept, keep, rd_en;
  d8fd_pkg::item_t      item;
  logic                 s1_vld_q;
  d8fd_pkg::item_t      s1_item_q;
  logic                 s1_adv, win_ready;
  d8fd_pkg::line_pair_t rd_data, wr_data;
  logic                 s2_vld, s2_ready;
  d8fd_pkg::s2_t        s2;

  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rd_en         = accept && keep;
  assign s1_adv        = s1_vld_q && win_ready;

  d8fd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .cmd_i       (s_axis_tuser),
    .elev_i      (s_axis_tdata[d8fd_pkg::ElevW-1:0]),
    .keep_o      (keep),
    .item_o      (item)
  );

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_item_q <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (rd_en) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  assign wr_data.older  = rd_data.recent;
  assign wr_data.recent = s1_item_q.value;

  d8fd_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (item.col),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_item_q.col),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  d8fd_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (s1_adv),
    .lines_i    (rd_data),
    .value_i    (s1_item_q.value),
    .primed_i   (s1_item_q.primed),
    .emit_i     (s1_item_q.emit),
    .ready_o    (win_ready),
    .s2_vld_o   (s2_vld),
    .s2_o       (s2),
    .s2_ready_i (s2_ready)
  );

  d8fd_pick u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_vld_i    (s2_vld),
    .s2_i        (s2),
    .s2_ready_o  (s2_ready),
    .out_vld_o   (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
